// ===== hdl/tlpt_pkg.sv =====
// shared types and constants for the two-level page table mapper
`timescale 1ns / 1ps

package tlpt_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = 10;
    localparam int TNUM_W        = 10;
    localparam int FRAME_W       = 20;
    localparam int SLOT_W        = TNUM_W + IDX_W;
    localparam int OFFSET_W      = 12;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_TABLE   = 2'd1,
        ST_DIR_ABSENT = 2'd2,
        ST_TBL_ABSENT = 2'd3
    } t_status;

    typedef enum logic {
        MODE_MAP   = 1'b0,
        MODE_XLATE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TBL
    } t_state;

    typedef struct packed {
        logic              present;
        logic              writable;
        logic              supervisor;
        logic [TNUM_W-1:0] table_num;
    } t_dir_entry;

    typedef struct packed {
        logic               present;
        logic               writable;
        logic               supervisor;
        logic [FRAME_W-1:0] frame;
    } t_page_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_dir_entry       wr_data;
    } t_dir_req;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        t_page_entry       wr_data;
    } t_tbl_req;

endpackage

// ===== hdl/tlpt_dir_ram.sv =====
// page directory memory, one read and one write port, registered read
`timescale 1ns / 1ps

module tlpt_dir_ram (
    input  logic                  i_clk,
    input  tlpt_pkg::t_dir_req    i_req,
    output tlpt_pkg::t_dir_entry  o_rdata
);
    import tlpt_pkg::*;

    t_dir_entry mem [DIR_ENTRIES];
    t_dir_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlpt_tbl_ram.sv =====
// second-level table pool memory, one read and one write port, registered read
`timescale 1ns / 1ps

module tlpt_tbl_ram #(
    parameter int NUM_TABLES = 16
) (
    input  logic                   i_clk,
    input  tlpt_pkg::t_tbl_req     i_req,
    output tlpt_pkg::t_page_entry  o_rdata
);
    import tlpt_pkg::*;

    localparam int DEPTH  = NUM_TABLES * TABLE_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);

    t_page_entry mem [DEPTH];
    t_page_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_slot[ADDR_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_slot[ADDR_W-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlpt_ctrl.sv =====
// walk sequencer: clearing pass, directory and table access, result register
`timescale 1ns / 1ps

module tlpt_ctrl #(
    parameter int NUM_TABLES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [31:0]                   i_virtual_address,
    input  logic [tlpt_pkg::FRAME_W-1:0]  i_physical_page,
    input  logic [1:0]                    i_access_flags,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_physical_address,
    output tlpt_pkg::t_dir_req            o_dir_req,
    input  tlpt_pkg::t_dir_entry          i_dir_rdata,
    output tlpt_pkg::t_tbl_req            o_tbl_req,
    input  tlpt_pkg::t_page_entry         i_tbl_rdata
);
    import tlpt_pkg::*;

    localparam int TBL_DEPTH = NUM_TABLES * TABLE_ENTRIES;
    localparam int CLR_W     = $clog2(TBL_DEPTH);
    localparam int NF_W      = $clog2(NUM_TABLES + 1);

    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic [NF_W-1:0]    r_next_free, n_next_free;
    logic               r_mode, n_mode;
    logic [31:0]        r_va, n_va;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [1:0]         r_flags, n_flags;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    logic [31:0]        r_out_pa, n_out_pa;

    logic              out_free;
    logic              pool_empty;
    logic [IDX_W-1:0]  tidx;
    logic [TNUM_W-1:0] tnum;

    assign out_free   = !r_out_valid || i_out_ready;
    assign pool_empty = (r_next_free == NF_W'(NUM_TABLES));
    assign tidx       = r_va[OFFSET_W +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_va         <= n_va;
        r_frame      <= n_frame;
        r_flags      <= n_flags;
        r_out_status <= n_out_status;
        r_out_pa     <= n_out_pa;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_next_free  = r_next_free;
        n_mode       = r_mode;
        n_va         = r_va;
        n_frame      = r_frame;
        n_flags      = r_flags;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_pa     = r_out_pa;
        o_in_ready   = 1'b0;
        o_dir_req    = '0;
        o_tbl_req    = '0;
        tnum         = i_dir_rdata.present ? i_dir_rdata.table_num : TNUM_W'(r_next_free);

        case (r_state)
            S_CLEAR: begin
                o_dir_req.wr_en   = 1'b1;
                o_dir_req.wr_addr = r_clr_cnt[IDX_W-1:0];
                o_tbl_req.wr_en   = 1'b1;
                o_tbl_req.wr_slot = SLOT_W'(r_clr_cnt);
                n_clr_cnt         = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode            = i_mode;
                    n_va              = i_virtual_address;
                    n_frame           = i_physical_page;
                    n_flags           = i_access_flags;
                    o_dir_req.rd_en   = 1'b1;
                    o_dir_req.rd_addr = i_virtual_address[31 -: IDX_W];
                    n_state           = S_DIR;
                end
            end
            S_DIR: begin
                if (r_mode == MODE_XLATE) begin
                    if (i_dir_rdata.present) begin
                        o_tbl_req.rd_en   = 1'b1;
                        o_tbl_req.rd_slot = {i_dir_rdata.table_num, tidx};
                        n_state           = S_TBL;
                    end else if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_DIR_ABSENT;
                        n_out_pa     = '0;
                        n_state      = S_IDLE;
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pa    = '0;
                    n_state     = S_IDLE;
                    if (!i_dir_rdata.present && pool_empty) begin
                        n_out_status = ST_NO_TABLE;
                    end else begin
                        n_out_status = ST_OK;
                        if (!i_dir_rdata.present) begin
                            o_dir_req.wr_en                = 1'b1;
                            o_dir_req.wr_addr              = r_va[31 -: IDX_W];
                            o_dir_req.wr_data.present      = 1'b1;
                            o_dir_req.wr_data.writable     = r_flags[0];
                            o_dir_req.wr_data.supervisor   = r_flags[1];
                            o_dir_req.wr_data.table_num    = tnum;
                            n_next_free                    = r_next_free + 1'b1;
                        end
                        o_tbl_req.wr_en              = 1'b1;
                        o_tbl_req.wr_slot            = {tnum, tidx};
                        o_tbl_req.wr_data.present    = 1'b1;
                        o_tbl_req.wr_data.writable   = r_flags[0];
                        o_tbl_req.wr_data.supervisor = r_flags[1];
                        o_tbl_req.wr_data.frame      = r_frame;
                    end
                end
            end
            S_TBL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (i_tbl_rdata.present) begin
                        n_out_status = ST_OK;
                        n_out_pa     = {i_tbl_rdata.frame, r_va[OFFSET_W-1:0]};
                    end else begin
                        n_out_status = ST_TBL_ABSENT;
                        n_out_pa     = '0;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_physical_address = r_out_pa;

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NF_W'(NUM_TABLES))
        else $error("table pool count beyond pool size");

    a_alloc_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_next_free != $past(r_next_free)) |->
            ($past(r_state) == S_DIR) && ($past(r_mode) == MODE_MAP)
            && (r_next_free == $past(r_next_free) + 1'b1))
        else $error("table allocated outside a map step");

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |->
            ($past(r_state) == S_DIR) || ($past(r_state) == S_TBL))
        else $error("result produced outside a walk step");

    a_no_write_on_xlate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIR) && (r_mode == MODE_XLATE) |->
            !o_dir_req.wr_en && !o_tbl_req.wr_en)
        else $error("translate modified the page tables");
`endif

endmodule

// ===== hdl/two_level_page_table_mapper.sv =====
// top level of the two-level page table mapper
`timescale 1ns / 1ps
// walk: map reads the directory, then writes the result register; translate reads
//   the dependent directory then table entries through single-port-read synchronous
//   memories; a step waits while a result is held, and a new item is taken only in idle
// reset: synchronous; then a clearing pass over every table slot marks every
//   directory and table entry absent, with input ready held low until it is done

module two_level_page_table_mapper #(
    parameter int NUM_TABLES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [31:0]                   i_virtual_address,
    input  logic [tlpt_pkg::FRAME_W-1:0]  i_physical_page,
    input  logic [1:0]                    i_access_flags,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_physical_address
);
    import tlpt_pkg::*;

    // request and read-data buses between the sequencer and the two memories
    t_dir_req    dir_req;
    t_dir_entry  dir_rdata;
    t_tbl_req    tbl_req;
    t_page_entry tbl_rdata;

    // sequencer: owns the pool counter, the captured item and the result register
    tlpt_ctrl #(
        .NUM_TABLES (NUM_TABLES)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_virtual_address  (i_virtual_address),
        .i_physical_page    (i_physical_page),
        .i_access_flags     (i_access_flags),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_physical_address (o_physical_address),
        .o_dir_req          (dir_req),
        .i_dir_rdata        (dir_rdata),
        .o_tbl_req          (tbl_req),
        .i_tbl_rdata        (tbl_rdata)
    );

    // page directory, indexed by virtual address bits 31:22
    tlpt_dir_ram u_dir_ram (
        .i_clk   (i_clk),
        .i_req   (dir_req),
        .o_rdata (dir_rdata)
    );

    // table pool, indexed by table number joined with virtual address bits 21:12
    tlpt_tbl_ram #(
        .NUM_TABLES (NUM_TABLES)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

endmodule
